### hdl/interval_merge_core_assert.svh
// Assertion macros used by the checker file.
`ifndef INTERVAL_MERGE_CORE_ASSERT_SVH
`define INTERVAL_MERGE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define IMC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define IMC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/imc_pkg.sv
`timescale 1ns / 1ps

package imc_pkg;

	localparam logic [2:0] RA_ZERO   = 3'd0;
	localparam logic [2:0] RA_ONE    = 3'd1;
	localparam logic [2:0] RA_CNT_M1 = 3'd2;
	localparam logic [2:0] RA_J_M2   = 3'd3;
	localparam logic [2:0] RA_I      = 3'd4;
	localparam logic [2:0] RA_I_P1   = 3'd5;

	typedef struct packed {
		logic [2:0] ra_sel;
		logic       key_load;
		logic       wr_key;
		logic       wr_shift;
		logic       cnt_inc;
		logic       cnt_clr;
		logic       ovf_set;
		logic       ovf_clr;
		logic       cur_load;
		logic       cur_ext;
		logic       i_set1;
		logic       i_inc;
		logic       out_load;
		logic       out_final;
	} cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic cnt_full;
		logic gt;
		logic j_one;
		logic overlap;
		logic i_last;
		logic n_one;
		logic out_free;
	} sts_t;

endpackage

### hdl/imc_ctrl.sv
`timescale 1ns / 1ps

module imc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	input  logic          last,
	output logic          item_stall,
	input  imc_pkg::sts_t sts,
	output imc_pkg::cmd_t cmd
);

	localparam logic [2:0] ST_IDLE        = 3'd0;
	localparam logic [2:0] ST_SHIFT       = 3'd1;
	localparam logic [2:0] ST_PLACE       = 3'd2;
	localparam logic [2:0] ST_MERGE_ADDR  = 3'd3;
	localparam logic [2:0] ST_MERGE_FIRST = 3'd4;
	localparam logic [2:0] ST_MERGE       = 3'd5;
	localparam logic [2:0] ST_EMIT_LAST   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       last_q;
	logic       last_d;
	logic       set_done;

	assign item_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		last_d   = last_q;
		set_done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					if (!sts.cnt_full) begin
						cmd.key_load = 1'b1;
						cmd.ra_sel   = imc_pkg::RA_CNT_M1;
						last_d       = last;
						state_d      = sts.cnt_zero ? ST_PLACE : ST_SHIFT;
					end else begin
						cmd.ovf_set = 1'b1;
						if (last) begin
							state_d = ST_MERGE_ADDR;
						end
					end
				end
			end
			ST_SHIFT: begin
				if (sts.gt) begin
					cmd.wr_shift = 1'b1;
					cmd.ra_sel   = imc_pkg::RA_J_M2;
					if (sts.j_one) begin
						state_d = ST_PLACE;
					end
				end else begin
					cmd.wr_key  = 1'b1;
					cmd.cnt_inc = 1'b1;
					set_done    = 1'b1;
				end
			end
			ST_PLACE: begin
				cmd.wr_key  = 1'b1;
				cmd.cnt_inc = 1'b1;
				set_done    = 1'b1;
			end
			ST_MERGE_ADDR: begin
				cmd.ra_sel = imc_pkg::RA_ZERO;
				state_d    = ST_MERGE_FIRST;
			end
			ST_MERGE_FIRST: begin
				cmd.cur_load = 1'b1;
				cmd.i_set1   = 1'b1;
				cmd.ra_sel   = imc_pkg::RA_ONE;
				state_d      = sts.n_one ? ST_EMIT_LAST : ST_MERGE;
			end
			ST_MERGE: begin
				cmd.ra_sel = imc_pkg::RA_I;
				if (sts.overlap || sts.out_free) begin
					if (sts.overlap) begin
						cmd.cur_ext = 1'b1;
					end else begin
						cmd.out_load = 1'b1;
						cmd.cur_load = 1'b1;
					end
					if (sts.i_last) begin
						state_d = ST_EMIT_LAST;
					end else begin
						cmd.i_inc  = 1'b1;
						cmd.ra_sel = imc_pkg::RA_I_P1;
					end
				end
			end
			ST_EMIT_LAST: begin
				if (sts.out_free) begin
					cmd.out_load  = 1'b1;
					cmd.out_final = 1'b1;
					cmd.cnt_clr   = 1'b1;
					cmd.ovf_clr   = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (set_done) begin
			state_d = last_q ? ST_MERGE_ADDR : ST_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			last_q  <= last_d;
		end
	end

endmodule

### hdl/imc_datapath.sv
`timescale 1ns / 1ps

module imc_datapath #(
	parameter int MAX_INTERVALS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  imc_pkg::cmd_t      cmd,
	output imc_pkg::sts_t      sts,
	input  logic signed [31:0] start_req,
	input  logic signed [31:0] finish,
	output logic               merge_valid,
	input  logic               merge_stall,
	output logic signed [31:0] merged_start,
	output logic signed [31:0] merged_finish,
	output logic               final_res,
	output logic               dropped
);

	localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
	localparam int CW = $clog2(MAX_INTERVALS + 1);

	logic signed [31:0] mem_start [MAX_INTERVALS];
	logic signed [31:0] mem_finish [MAX_INTERVALS];

	logic signed [31:0] rd_start_q;
	logic signed [31:0] rd_finish_q;
	logic signed [31:0] key_start_q;
	logic signed [31:0] key_finish_q;
	logic signed [31:0] cur_start_q;
	logic signed [31:0] cur_finish_q;
	logic signed [31:0] out_start_q;
	logic signed [31:0] out_finish_q;
	logic               out_final_q;
	logic               out_dropped_q;
	logic               out_valid_q;
	logic [AW-1:0]      j_q;
	logic [AW-1:0]      i_q;
	logic [CW-1:0]      count_q;
	logic               ovf_q;
	logic [AW-1:0]      raddr;
	logic               out_free;

	always_comb begin
		case (cmd.ra_sel)
			imc_pkg::RA_ZERO:   raddr = '0;
			imc_pkg::RA_ONE:    raddr = AW'(1);
			imc_pkg::RA_CNT_M1: raddr = AW'(count_q - CW'(1));
			imc_pkg::RA_J_M2:   raddr = j_q - AW'(2);
			imc_pkg::RA_I:      raddr = i_q;
			imc_pkg::RA_I_P1:   raddr = i_q + AW'(1);
			default:            raddr = '0;
		endcase
	end

	assign out_free = !out_valid_q || !merge_stall;

	always_comb begin
		sts.cnt_zero = (count_q == '0);
		sts.cnt_full = (count_q == CW'(MAX_INTERVALS));
		sts.gt       = (rd_start_q > key_start_q);
		sts.j_one    = (j_q == AW'(1));
		sts.overlap  = (rd_start_q <= cur_finish_q);
		sts.i_last   = ((CW'(i_q) + CW'(1)) == count_q);
		sts.n_one    = (count_q == CW'(1));
		sts.out_free = out_free;
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_key) begin
			mem_start[j_q]  <= key_start_q;
			mem_finish[j_q] <= key_finish_q;
		end else if (cmd.wr_shift) begin
			mem_start[j_q]  <= rd_start_q;
			mem_finish[j_q] <= rd_finish_q;
		end
		rd_start_q  <= mem_start[raddr];
		rd_finish_q <= mem_finish[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.key_load) begin
			key_start_q  <= start_req;
			key_finish_q <= finish;
		end
		if (cmd.cur_load) begin
			cur_start_q  <= rd_start_q;
			cur_finish_q <= rd_finish_q;
		end else if (cmd.cur_ext && (rd_finish_q > cur_finish_q)) begin
			cur_finish_q <= rd_finish_q;
		end
		if (cmd.out_load) begin
			out_start_q   <= cur_start_q;
			out_finish_q  <= cmd.cur_ext ? cur_finish_q : cur_finish_q;
			out_final_q   <= cmd.out_final;
			out_dropped_q <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			j_q         <= '0;
			i_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_clr) begin
				count_q <= '0;
			end else if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.ovf_clr) begin
				ovf_q <= 1'b0;
			end else if (cmd.ovf_set) begin
				ovf_q <= 1'b1;
			end
			if (cmd.key_load) begin
				j_q <= count_q[AW-1:0];
			end else if (cmd.wr_shift) begin
				j_q <= j_q - AW'(1);
			end
			if (cmd.i_set1) begin
				i_q <= AW'(1);
			end else if (cmd.i_inc) begin
				i_q <= i_q + AW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!merge_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign merge_valid   = out_valid_q;
	assign merged_start  = out_start_q;
	assign merged_finish = out_finish_q;
	assign final_res     = out_final_q;
	assign dropped       = out_dropped_q;

endmodule

### hdl/interval_merge_core.sv
`timescale 1ns / 1ps
// Channel  | Signals                                          | Transaction
// item     | item_valid, item_stall, start_req, finish, last  | one interval in
// merge    | merge_valid, merge_stall, merged_start,          | one merged interval out
//          | merged_finish, final_res, dropped                |
// Each interval is insertion-sorted into a single-port-write memory as it arrives,
// each stored entry with a larger start moving up one place. An interval offered
// while the memory is full is dropped and not stored.
// After the last transaction the merge sweep reads the memory once, one entry a
// cycle; a held merge_stall pauses it only when a merged interval is to be emitted.
// The asynchronous reset empties the set; the memory itself is not cleared.
// No new transaction is taken until the set is out.

module interval_merge_core #(
	parameter int MAX_INTERVALS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic signed [31:0] start_req,
	input  logic signed [31:0] finish,
	input  logic               last,
	output logic               merge_valid,
	input  logic               merge_stall,
	output logic signed [31:0] merged_start,
	output logic signed [31:0] merged_finish,
	output logic               final_res,
	output logic               dropped
);

	imc_pkg::cmd_t cmd;
	imc_pkg::sts_t sts;

	imc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.last       (last),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	imc_datapath #(
		.MAX_INTERVALS (MAX_INTERVALS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.start_req     (start_req),
		.finish        (finish),
		.merge_valid   (merge_valid),
		.merge_stall   (merge_stall),
		.merged_start  (merged_start),
		.merged_finish (merged_finish),
		.final_res     (final_res),
		.dropped       (dropped)
	);

endmodule

### hdl/imc_checker.sv
`timescale 1ns / 1ps
`include "interval_merge_core_assert.svh"

module imc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_stall,
	input logic        last,
	input logic        merge_valid,
	input logic        merge_stall,
	input logic [31:0] merged_start,
	input logic [31:0] merged_finish,
	input logic        final_res,
	input logic        dropped
);

	`IMC_ASSERT_NEXT(a_merge_hold, merge_valid && merge_stall, merge_valid && $stable(merged_start) && $stable(merged_finish) && $stable(final_res) && $stable(dropped), "stalled merge transaction changed")
	`IMC_ASSERT_SAME(a_busy_mid_set, merge_valid && !final_res, item_stall, "item taken while a set is still being emitted")
	`IMC_ASSERT_NEXT(a_busy_after_last, item_valid && !item_stall && last, item_stall, "item taken right after the last of a set")

endmodule

bind interval_merge_core imc_checker u_imc_checker (.*);

### dv/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int STORE_DEPTH = 32;
	localparam int NPLAN = 24;
	localparam int HOLD_CYCLES = 200;
	localparam int WATCHDOG = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam logic signed [31:0] INT_LO = 32'sh8000_0000;
	localparam logic signed [31:0] INT_HI = 32'sh7fff_ffff;

	typedef struct packed {
		logic signed [31:0] open_at;
		logic signed [31:0] close_at;
	} ival_t;

	typedef struct packed {
		logic signed [31:0] mstart;
		logic signed [31:0] mfinish;
		logic               fin;
		logic               drp;
	} merged_t;

	typedef struct packed {
		logic signed [31:0] s;
		logic signed [31:0] f;
		logic               l;
		logic               typed;
		logic signed [31:0] es;
		logic signed [31:0] ef;
		logic               ed;
	} row_t;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	logic signed [31:0] start_req;
	logic signed [31:0] finish;
	logic last;
	logic merge_valid;
	logic merge_stall;
	logic signed [31:0] merged_start;
	logic signed [31:0] merged_finish;
	logic final_res;
	logic dropped;

	logic row_typed;
	merged_t row_want;

	ival_t pending[$];
	logic overflow_hit;
	merged_t fresh_spans[$];
	merged_t due_spans[$];

	int errors;
	int stuck;
	bit hold_req;
	bit calm;

	row_t plan [NPLAN] = '{
		'{INT_LO, INT_HI, 1'b1, 1'b1, INT_LO, INT_HI, 1'b0},
		'{INT_HI, INT_LO, 1'b1, 1'b1, INT_HI, INT_LO, 1'b0},
		'{32'sd0, 32'sd0, 1'b1, 1'b1, 32'sd0, 32'sd0, 1'b0},
		'{-32'sd1, -32'sd1, 1'b1, 1'b1, -32'sd1, -32'sd1, 1'b0},
		'{32'sd5, 32'sd10, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0},
		'{32'sd1, 32'sd3, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0},
		'{32'sd2, 32'sd6, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0},
		'{-32'sd4, -32'sd1, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0},
		'{32'sd20, 32'sd30, 1'b1, 1'b0, 32'sd0, 32'sd0, 1'b0},
		'{32'sd7, 32'sd8, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0},
		'{32'sd7, 32'sd12, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0},
		'{32'sd7, 32'sd3, 1'b1, 1'b0, 32'sd0, 32'sd0, 1'b0},
		'{32'sd1, 32'sd5, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0},
		'{32'sd5, 32'sd9, 1'b1, 1'b0, 32'sd0, 32'sd0, 1'b0},
		'{32'sd1, 32'sd5, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0},
		'{32'sd6, 32'sd9, 1'b1, 1'b0, 32'sd0, 32'sd0, 1'b0},
		'{32'sd10, 32'sd2, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0},
		'{32'sd3, 32'sd4, 1'b1, 1'b0, 32'sd0, 32'sd0, 1'b0},
		'{INT_HI, INT_HI, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0},
		'{INT_LO, INT_LO, 1'b1, 1'b0, 32'sd0, 32'sd0, 1'b0},
		'{INT_LO, 32'sd0, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0},
		'{-32'sd1, INT_HI, 1'b1, 1'b0, 32'sd0, 32'sd0, 1'b0},
		'{32'shaaaa_aaaa, 32'sh5555_5555, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0},
		'{32'sh5555_5555, 32'shaaaa_aaaa, 1'b1, 1'b0, 32'sd0, 32'sd0, 1'b0}
	};

	interval_merge_core #(
		.MAX_INTERVALS(STORE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.start_req(start_req),
		.finish(finish),
		.last(last),
		.merge_valid(merge_valid),
		.merge_stall(merge_stall),
		.merged_start(merged_start),
		.merged_finish(merged_finish),
		.final_res(final_res),
		.dropped(dropped)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void absorb_interval(input logic signed [31:0] s,
			input logic signed [31:0] f, input logic l);
		ival_t sorted[$];
		ival_t cur;
		ival_t p;
		merged_t m;
		int j;
		if (pending.size() < STORE_DEPTH) begin
			p.open_at = s;
			p.close_at = f;
			pending.push_back(p);
		end else begin
			overflow_hit = 1'b1;
		end
		if (!l)
			return;
		foreach (pending[i]) begin
			p = pending[i];
			sorted.push_back(p);
			j = sorted.size() - 1;
			while (j > 0 && sorted[j - 1].open_at > p.open_at) begin
				sorted[j] = sorted[j - 1];
				j--;
			end
			sorted[j] = p;
		end
		cur = sorted[0];
		for (int i = 1; i < sorted.size(); i++) begin
			if (sorted[i].open_at <= cur.close_at) begin
				if (sorted[i].close_at > cur.close_at)
					cur.close_at = sorted[i].close_at;
			end else begin
				m = '{cur.open_at, cur.close_at, 1'b0, overflow_hit};
				fresh_spans.push_back(m);
				cur = sorted[i];
			end
		end
		m = '{cur.open_at, cur.close_at, 1'b1, overflow_hit};
		fresh_spans.push_back(m);
		pending.delete();
		overflow_hit = 1'b0;
	endfunction

	function automatic void check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, what, $signed(want),
				$signed(got));
		end
	endfunction

	function automatic logic signed [31:0] pick_edge();
		case ($urandom_range(0, 4))
			0: return INT_LO;
			1: return INT_HI;
			2: return 32'sd0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	always @(posedge clk) begin
		merged_t want;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				absorb_interval(start_req, finish, last);
				if (row_typed) begin
					fresh_spans.delete();
					due_spans.push_back(row_want);
				end else begin
					while (fresh_spans.size() != 0)
						due_spans.push_back(fresh_spans.pop_front());
				end
			end
			if (merge_valid && !merge_stall) begin
				if (due_spans.size() == 0) begin
					errors++;
					$display("%0t: merged interval %0d..%0d with nothing expected", $time,
						merged_start, merged_finish);
				end else begin
					want = due_spans.pop_front();
					check_field("merged_start", want.mstart, merged_start);
					check_field("merged_finish", want.mfinish, merged_finish);
					check_field("final_res", {31'd0, want.fin}, {31'd0, final_res});
					check_field("dropped", {31'd0, want.drp}, {31'd0, dropped});
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (merge_valid && !merge_stall))
			stuck = 0;
		else
			stuck++;
		if (stuck == WATCHDOG) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		merge_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				merge_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				merge_stall <= 1'b0;
			end else if (!calm && quiet == 0 && $urandom_range(0, 5) == 0) begin
				merge_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				merge_stall <= 1'b0;
				if ($urandom_range(0, 2) == 0)
					quiet = $urandom_range(20, 80);
			end else if (quiet > 0) begin
				quiet--;
			end
		end
	end

	task automatic rest(input int cycles);
		item_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic offer(input logic signed [31:0] s, input logic signed [31:0] f,
			input logic l, input logic typed, input merged_t want);
		item_valid <= 1'b1;
		start_req <= s;
		finish <= f;
		last <= l;
		row_typed <= typed;
		row_want <= want;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	initial begin
		merged_t want;
		logic signed [31:0] base;
		logic signed [31:0] s;
		logic signed [31:0] f;
		int off;
		int n;
		int mode;
		int sent;
		int set_no;
		bit gappy;
		arst_n = 1'b0;
		item_valid = 1'b0;
		start_req = '0;
		finish = '0;
		last = 1'b0;
		row_typed = 1'b0;
		row_want = '0;
		overflow_hit = 1'b0;
		errors = 0;
		stuck = 0;
		hold_req = 0;
		calm = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NPLAN; i++) begin
			if ($urandom_range(0, 3) == 0)
				rest($urandom_range(1, 19));
			want = '{plan[i].es, plan[i].ef, 1'b1, plan[i].ed};
			offer(plan[i].s, plan[i].f, plan[i].l, plan[i].typed, want);
		end

		want = '0;
		sent = 0;
		set_no = 0;
		while (sent < 176) begin
			case (set_no)
				0: n = STORE_DEPTH + 1;
				1: n = STORE_DEPTH + 3;
				default: n = ($urandom_range(0, 19) == 0) ?
					$urandom_range(STORE_DEPTH - 2, STORE_DEPTH + 2) : $urandom_range(1, 8);
			endcase
			if (set_no == 1)
				hold_req = 1;
			calm = (sent >= 150);
			gappy = !calm && $urandom_range(0, 2) != 0;
			mode = (set_no == 0) ? 4 : $urandom_range(0, 3);
			base = $urandom_range(0, 4000) - 2000;
			for (int k = 0; k < n; k++) begin
				if (gappy && $urandom_range(0, 3) == 0)
					rest($urandom_range(1, 19));
				case (mode)
					0: begin
						s = $urandom;
						f = $urandom;
					end
					1: begin
						s = pick_edge();
						f = pick_edge();
					end
					4: begin
						s = base - k * 40;
						f = s + 5;
					end
					default: begin
						off = $urandom_range(0, 60) - 30;
						s = base + off;
						off = $urandom_range(0, 24) - 4;
						f = s + off;
					end
				endcase
				offer(s, f, k == n - 1, 1'b0, want);
				sent++;
			end
			if (set_no == 3) begin
				item_valid <= 1'b0;
				@(posedge clk);
				while (due_spans.size() != 0) @(posedge clk);
			end
			set_no++;
		end
		item_valid <= 1'b0;

		while (due_spans.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### files.f
+incdir+hdl
hdl/imc_pkg.sv
hdl/imc_ctrl.sv
hdl/imc_datapath.sv
hdl/interval_merge_core.sv
hdl/imc_checker.sv
dv/tb.sv
